@@ sv/svpc_pkg.sv @@
package svpc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ITER_W = $clog2(CORDIC_STAGES);

    localparam logic [1:0] OP_ANGLE       = 2'd0;
    localparam logic [1:0] OP_ALPHA_BETA  = 2'd1;
    localparam logic [1:0] OP_VECTOR      = 2'd2;

    localparam logic [1:0] REG_PERIOD     = 2'd0;
    localparam logic [1:0] REG_DUTY_CEIL  = 2'd1;
    localparam logic [1:0] REG_SUPPLY     = 2'd2;

    localparam logic [15:0] PERIOD_RST    = 16'd4199;
    localparam logic [15:0] DUTY_CEIL_RST = 16'd62259;
    localparam logic [15:0] SUPPLY_RST    = 16'd3072;

    localparam logic signed [31:0] GAIN_INV    = 32'sd652032874;
    localparam logic signed [31:0] K_INV_SQRT3 = 32'sd619924842;
    localparam logic signed [31:0] K_TWO_SQRT3 = 32'sd1239849684;
    localparam logic [15:0]        K_VMAX      = 16'd37574;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

    localparam logic signed [27:0] DEG_90  = 28'sd5898240;
    localparam logic signed [27:0] DEG_180 = 28'sd11796480;
    localparam logic signed [27:0] DEG_360 = 28'sd23592960;

    typedef enum logic [1:0] {
        MODE_ANGLE,
        MODE_ALPHA_BETA,
        MODE_VECTOR
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [15:0]        angle;
        logic [15:0]        duty;
        logic signed [15:0] volt_alpha;
        logic signed [15:0] volt_beta;
        logic [2:0]         vector_bits;
    } t_item;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] duty_ceil;
        logic [15:0] supply;
    } t_cfg;

    function automatic logic signed [27:0] atan_q16(input logic [4:0] idx);
        logic signed [27:0] v;
        case (idx)
            5'd0:    v = 28'sd2949120;
            5'd1:    v = 28'sd1740967;
            5'd2:    v = 28'sd919879;
            5'd3:    v = 28'sd466945;
            5'd4:    v = 28'sd234379;
            5'd5:    v = 28'sd117265;
            5'd6:    v = 28'sd58666;
            5'd7:    v = 28'sd29335;
            5'd8:    v = 28'sd14668;
            5'd9:    v = 28'sd7334;
            5'd10:   v = 28'sd3667;
            5'd11:   v = 28'sd1833;
            5'd12:   v = 28'sd917;
            5'd13:   v = 28'sd458;
            5'd14:   v = 28'sd229;
            5'd15:   v = 28'sd115;
            5'd16:   v = 28'sd57;
            5'd17:   v = 28'sd29;
            5'd18:   v = 28'sd14;
            5'd19:   v = 28'sd7;
            5'd20:   v = 28'sd4;
            5'd21:   v = 28'sd2;
            5'd22:   v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [12:0] mod5760(input logic [15:0] a);
        logic [15:0] r;
        r = a;
        if (r >= 16'd46080) r = r - 16'd46080;
        if (r >= 16'd23040) r = r - 16'd23040;
        if (r >= 16'd11520) r = r - 16'd11520;
        if (r >= 16'd5760)  r = r - 16'd5760;
        return r[12:0];
    endfunction

    function automatic logic [2:0] sector_of(input logic [12:0] a);
        logic [2:0] s;
        if (a >= 13'd4800)      s = 3'd5;
        else if (a >= 13'd3840) s = 3'd4;
        else if (a >= 13'd2880) s = 3'd3;
        else if (a >= 13'd1920) s = 3'd2;
        else if (a >= 13'd960)  s = 3'd1;
        else                    s = 3'd0;
        return s;
    endfunction

    function automatic logic [2:0] sector_first(input logic [2:0] s);
        logic [2:0] v;
        case (s)
            3'd0:    v = 3'd4;
            3'd1:    v = 3'd6;
            3'd2:    v = 3'd2;
            3'd3:    v = 3'd3;
            3'd4:    v = 3'd1;
            default: v = 3'd5;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] sector_second(input logic [2:0] s);
        logic [2:0] v;
        case (s)
            3'd0:    v = 3'd6;
            3'd1:    v = 3'd2;
            3'd2:    v = 3'd3;
            3'd3:    v = 3'd1;
            3'd4:    v = 3'd5;
            default: v = 3'd4;
        endcase
        return v;
    endfunction

endpackage

@@ sv/svpc_front.sv @@
module svpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [1:0]           i_op,
    input  logic [15:0]          i_angle,
    input  logic [15:0]          i_duty,
    input  logic signed [15:0]   i_volt_alpha,
    input  logic signed [15:0]   i_volt_beta,
    input  logic [2:0]           i_vector_bits,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output svpc_pkg::t_item      o_item
);

    svpc_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    svpc_pkg::t_item n_item;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        n_item.angle       = i_angle;
        n_item.duty        = i_duty;
        n_item.volt_alpha  = i_volt_alpha;
        n_item.volt_beta   = i_volt_beta;
        n_item.vector_bits = i_vector_bits;
        unique case (i_op)
            svpc_pkg::OP_ALPHA_BETA: n_item.mode = svpc_pkg::MODE_ALPHA_BETA;
            svpc_pkg::OP_VECTOR:     n_item.mode = svpc_pkg::MODE_VECTOR;
            default:                 n_item.mode = svpc_pkg::MODE_ANGLE;
        endcase
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            if (do_push && !do_pop)      r_count <= r_count + 2'd1;
            else if (!do_push && do_pop) r_count <= r_count - 2'd1;
        end
    end

endmodule

@@ sv/svpc_div.sv @@
module svpc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [15:0] r_num;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic [32:0] trial;
    logic        fits;

    assign trial      = {r_rem, r_num[15]};
    assign fits       = (trial >= {1'b0, r_div});
    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div <= i_divisor;
                if (i_divisor == 32'd0) begin
                    r_q    <= (i_dividend != 48'd0) ? 16'hFFFF : 16'h0000;
                    r_done <= 1'b1;
                end else if (i_dividend[47:16] >= i_divisor) begin
                    r_q    <= 16'hFFFF;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_dividend[47:16];
                    r_num  <= i_dividend[15:0];
                    r_q    <= 16'h0000;
                    r_cnt  <= 4'd15;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= fits ? 32'(trial - {1'b0, r_div}) : trial[31:0];
                r_num <= {r_num[14:0], 1'b0};
                r_q   <= {r_q[14:0], fits};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ sv/svpc_core.sv @@
module svpc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  svpc_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  svpc_pkg::t_item      i_item,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [15:0]          o_compare_a,
    output logic [15:0]          o_compare_b,
    output logic [15:0]          o_compare_c,
    output logic [2:0]           o_sector
);

    typedef enum logic [3:0] {
        S_IDLE, S_VEC, S_MAG, S_DIVS, S_DIVW, S_ANG, S_ROT,
        S_MX, S_MY, S_MC1, S_MC2, S_TIME, S_CA, S_CB, S_CC
    } t_state;

    t_state                    r_state;
    logic [svpc_pkg::ITER_W-1:0] r_iter;
    logic signed [35:0]        r_x;
    logic signed [35:0]        r_y;
    logic signed [27:0]        r_z;
    logic                      r_neg;
    logic [15:0]               r_angle;
    logic [15:0]               r_duty;
    logic [15:0]               r_d;
    logic [2:0]                r_sector;
    logic [29:0]               r_mag;
    logic signed [35:0]        r_c1y;
    logic signed [35:0]        r_c2y;
    logic signed [35:0]        r_p [3];
    logic [15:0]               r_cmp_a;
    logic [15:0]               r_cmp_b;

    logic signed [35:0] m_a;
    logic signed [31:0] m_b;
    logic signed [67:0] m_p;
    logic signed [67:0] sh16;
    logic signed [67:0] sh30;
    logic [15:0]        cmp_sat;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic signed [27:0] at;
    logic               last_iter;
    logic               div_start;
    logic               div_done;
    logic [15:0]        div_q;
    logic [31:0]        divisor;
    logic signed [35:0] t1;
    logic signed [35:0] t2;
    logic signed [35:0] t0;
    logic [2:0]         vf;
    logic [2:0]         vs;
    logic signed [27:0] zq;
    logic [15:0]        ang_r;
    logic [12:0]        a_mod;
    logic signed [27:0] zf;
    logic signed [35:0] x0;
    logic signed [35:0] y0;
    logic [15:0]        d_in;

    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign div_start = (r_state == S_DIVS);
    assign divisor   = i_cfg.supply * svpc_pkg::K_VMAX;
    assign sx        = r_x >>> r_iter;
    assign sy        = r_y >>> r_iter;
    assign at        = svpc_pkg::atan_q16(5'(r_iter));
    assign last_iter = (r_iter == svpc_pkg::ITER_W'(svpc_pkg::CORDIC_STAGES - 1));
    assign d_in      = (i_item.duty > i_cfg.duty_ceil) ? i_cfg.duty_ceil : i_item.duty;
    assign x0        = 36'(i_item.volt_alpha) <<< 14;
    assign y0        = 36'(i_item.volt_beta) <<< 14;

    svpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_mag, 18'd0}),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        m_a = r_x;
        m_b = {16'd0, r_d};
        case (r_state)
            S_MAG:   begin m_a = r_x; m_b = svpc_pkg::GAIN_INV; end
            S_MX:    begin m_a = r_neg ? -r_x : r_x; m_b = {16'd0, r_d}; end
            S_MY:    begin m_a = r_y; m_b = {16'd0, r_d}; end
            S_MC1:   begin m_a = r_y; m_b = svpc_pkg::K_INV_SQRT3; end
            S_MC2:   begin m_a = r_y; m_b = svpc_pkg::K_TWO_SQRT3; end
            S_CA:    begin m_a = r_p[0]; m_b = {16'd0, i_cfg.period}; end
            S_CB:    begin m_a = r_p[1]; m_b = {16'd0, i_cfg.period}; end
            S_CC:    begin m_a = r_p[2]; m_b = {16'd0, i_cfg.period}; end
            default: begin m_a = r_x; m_b = {16'd0, r_d}; end
        endcase
        m_p  = m_a * m_b;
        sh16 = m_p >>> 16;
        sh30 = m_p >>> 30;
        if (sh30 < 0)                          cmp_sat = 16'd0;
        else if (sh30 > 68'sd0 + i_cfg.period) cmp_sat = i_cfg.period;
        else                                   cmp_sat = sh30[15:0];
    end

    always_comb begin
        zq    = (r_z < 0) ? r_z + svpc_pkg::DEG_360 : r_z;
        ang_r = 16'((zq + 28'sd2048) >>> 12);
        if (ang_r >= 16'd5760) ang_r = ang_r - 16'd5760;
        a_mod = svpc_pkg::mod5760(r_angle);
        zf    = 28'({a_mod, 12'd0});
        if (zf > svpc_pkg::DEG_180) zf = zf - svpc_pkg::DEG_360;
    end

    always_comb begin
        case (r_sector)
            3'd0:    begin t1 = r_x - r_c1y;  t2 = r_c2y;          end
            3'd1:    begin t1 = r_x + r_c1y;  t2 = r_c1y - r_x;    end
            3'd2:    begin t1 = r_c2y;        t2 = -r_x - r_c1y;   end
            3'd3:    begin t1 = r_c1y - r_x;  t2 = -r_c2y;         end
            3'd4:    begin t1 = -r_c1y - r_x; t2 = r_x - r_c1y;    end
            default: begin t1 = -r_c2y;       t2 = r_x + r_c1y;    end
        endcase
        t0 = (svpc_pkg::ONE_Q30 - t1 - t2) >>> 1;
        vf = svpc_pkg::sector_first(r_sector);
        vs = svpc_pkg::sector_second(r_sector);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_angle <= i_item.angle;
                        r_duty  <= i_item.duty;
                        r_iter  <= '0;
                        unique case (i_item.mode)
                            svpc_pkg::MODE_VECTOR: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_p[k] <= i_item.vector_bits[2-k]
                                        ? 36'({d_in, 14'd0}) : 36'sd0;
                                end
                                r_sector <= 3'd0;
                                r_state  <= S_CA;
                            end
                            svpc_pkg::MODE_ALPHA_BETA: begin
                                if (x0 < 0) begin
                                    r_x <= -x0;
                                    r_y <= -y0;
                                    r_z <= svpc_pkg::DEG_180;
                                end else begin
                                    r_x <= x0;
                                    r_y <= y0;
                                    r_z <= 28'sd0;
                                end
                                r_state <= S_VEC;
                            end
                            default: r_state <= S_ANG;
                        endcase
                    end
                end
                S_VEC: begin
                    if (r_y > 0) begin
                        r_x <= r_x + sy;
                        r_y <= r_y - sx;
                        r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - sy;
                        r_y <= r_y + sx;
                        r_z <= r_z - at;
                    end
                    r_iter <= r_iter + 1'b1;
                    if (last_iter) r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mag   <= (sh30 < 0) ? 30'd0 : sh30[29:0];
                    r_angle <= ang_r;
                    r_state <= S_DIVS;
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        r_duty  <= div_q;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_d      <= (r_duty > i_cfg.duty_ceil) ? i_cfg.duty_ceil : r_duty;
                    r_sector <= svpc_pkg::sector_of(a_mod);
                    r_x      <= 36'(svpc_pkg::GAIN_INV);
                    r_y      <= 36'sd0;
                    r_iter   <= '0;
                    if (zf > svpc_pkg::DEG_90) begin
                        r_z   <= zf - svpc_pkg::DEG_180;
                        r_neg <= 1'b1;
                    end else if (zf < -svpc_pkg::DEG_90) begin
                        r_z   <= zf + svpc_pkg::DEG_180;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= zf;
                        r_neg <= 1'b0;
                    end
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - sy;
                        r_y <= r_y + sx;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + sy;
                        r_y <= r_y - sx;
                        r_z <= r_z + at;
                    end
                    r_iter <= r_iter + 1'b1;
                    if (last_iter) r_state <= S_MX;
                end
                S_MX: begin
                    r_x <= sh16[35:0];
                    if (r_neg) r_y <= -r_y;
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_y     <= sh16[35:0];
                    r_state <= S_MC1;
                end
                S_MC1: begin
                    r_c1y   <= sh30[35:0];
                    r_state <= S_MC2;
                end
                S_MC2: begin
                    r_c2y   <= sh30[35:0];
                    r_state <= S_TIME;
                end
                S_TIME: begin
                    for (int k = 0; k < 3; k++) begin
                        r_p[k] <= t0 + (vf[2-k] ? t1 : 36'sd0) + (vs[2-k] ? t2 : 36'sd0);
                    end
                    r_sector <= r_sector + 3'd1;
                    r_state  <= S_CA;
                end
                S_CA: begin
                    r_cmp_a <= cmp_sat;
                    r_state <= S_CB;
                end
                S_CB: begin
                    r_cmp_b <= cmp_sat;
                    r_state <= S_CC;
                end
                S_CC: begin
                    o_compare_a <= r_cmp_a;
                    o_compare_b <= r_cmp_b;
                    o_compare_c <= cmp_sat;
                    o_sector    <= r_sector;
                    o_strobe    <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/space_vector_pwm_compare.sv @@
// channel      direction  handshake                        payload
// command      in         start, busy                      i_op, i_angle, i_duty,
//                                                          i_volt_alpha, i_volt_beta,
//                                                          i_vector_bits
// result       out        o_strobe (one cycle)             o_compare_a/b/c, o_sector
// config       in         i_cfg_valid, o_cfg_ready         i_cfg_index, i_cfg_data
//
// vector mode goes from the start transaction straight to the compare steps; angle mode
// first runs one 16-step cordic pass, alpha-beta mode two 16-step cordic passes and the
// 16-step divider, all with one shared multiplier; a queued command starts only once the
// previous result is out. a two-entry queue holds commands; busy is high when full.
// reset is synchronous, active low, and loads the register defaults.
// the receiver cannot stall; each result is flagged by o_strobe for one cycle.
module space_vector_pwm_compare (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_op,
    input  logic [15:0]         i_angle,
    input  logic [15:0]         i_duty,
    input  logic signed [15:0]  i_volt_alpha,
    input  logic signed [15:0]  i_volt_beta,
    input  logic [2:0]          i_vector_bits,
    output logic                o_strobe,
    output logic [15:0]         o_compare_a,
    output logic [15:0]         o_compare_b,
    output logic [15:0]         o_compare_c,
    output logic [2:0]          o_sector,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    svpc_pkg::t_cfg  r_cfg;
    svpc_pkg::t_item q_item;
    logic            q_valid;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period    <= svpc_pkg::PERIOD_RST;
            r_cfg.duty_ceil <= svpc_pkg::DUTY_CEIL_RST;
            r_cfg.supply    <= svpc_pkg::SUPPLY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                svpc_pkg::REG_PERIOD:    r_cfg.period    <= i_cfg_data;
                svpc_pkg::REG_DUTY_CEIL: r_cfg.duty_ceil <= i_cfg_data;
                svpc_pkg::REG_SUPPLY:    r_cfg.supply    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    svpc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (start),
        .i_op          (i_op),
        .i_angle       (i_angle),
        .i_duty        (i_duty),
        .i_volt_alpha  (i_volt_alpha),
        .i_volt_beta   (i_volt_beta),
        .i_vector_bits (i_vector_bits),
        .i_pop         (q_pop),
        .o_full        (busy),
        .o_valid       (q_valid),
        .o_item        (q_item)
    );

    svpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_compare_a (o_compare_a),
        .o_compare_b (o_compare_b),
        .o_compare_c (o_compare_c),
        .o_sector    (o_sector)
    );

endmodule
